FILE: src/npet_pkg.sv
// Package for the nearest pending entry table: widths, status codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package npet_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int LOC_W = 16;
    localparam int REF_W = 24;
    localparam int DIFF_W = 26;
    localparam int SQ_W = 50;
    localparam int DIST_W = 52;
    localparam int CMD_W = 1;
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_TAKEN    = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_TAKE   = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_SUM,
        S_CMP,
        S_FINISH,
        S_OUT
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [3*LOC_W-1:0] loc;
        logic [3*REF_W-1:0] refp;
    } t_job;
endpackage
`default_nettype wire

FILE: src/nearest_pending_entry_table.sv
// Top level of the nearest pending entry table; joins front queue and back end.
// Depends on npet_pkg, npet_front, npet_back.
// Insert scans the slot store one slot per step (scan, compare) and stops at a
// duplicate; take steps through scan, multiply, sum and compare for each slot.
// Throughput: one word at a time in the back end; the front queue holds two.
// Reset: synchronous active low; all slots empty, queue cleared.
`timescale 1ns / 1ps
`default_nettype none
module nearest_pending_entry_table
    import npet_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  s_axis_tvalid,
    output logic s_axis_tready,
    input  wire  [119:0] s_axis_tdata, // loc_x, loc_y, loc_z, ref_x, ref_y, ref_z
    input  wire  s_axis_tuser,         // command
    output logic m_axis_tvalid,
    input  wire  m_axis_tready,
    output logic [55:0] m_axis_tdata   // status, out_x, out_y, out_z, pad
);
    t_job job;
    logic job_valid, job_ready;
    t_status status;
    logic [3*LOC_W-1:0] loc;

    npet_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tuser),
        .i_loc(s_axis_tdata[47:0]), .i_ref(s_axis_tdata[119:48]),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    npet_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(status), .o_loc(loc)
    );

    assign m_axis_tdata = {5'd0, loc, status};
endmodule
`default_nettype wire

FILE: src/npet_front.sv
// Front end: accepts input words, classifies the command, and queues jobs.
// Depends on npet_pkg.
`timescale 1ns / 1ps
`default_nettype none
module npet_front
    import npet_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  wire  i_cmd,
    input  wire  [3*LOC_W-1:0] i_loc,
    input  wire  [3*REF_W-1:0] i_ref,
    output logic o_job_valid,
    input  wire  i_job_ready,
    output t_job o_job
);
    t_job r_q [QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].cmd  <= t_cmd'(i_cmd);
            r_q[r_wp].loc  <= i_cmd ? '0 : i_loc;
            r_q[r_wp].refp <= i_cmd ? i_ref : '0;
        end
    end
endmodule
`default_nettype wire

FILE: src/npet_back.sv
// Back end: slot store and scan sequencer for insert and take.
// Depends on npet_pkg.
`timescale 1ns / 1ps
`default_nettype none
module npet_back
    import npet_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_job_valid,
    output logic o_job_ready,
    input  t_job i_job,
    output logic o_valid,
    input  wire  i_ready,
    output t_status o_status,
    output logic [3*LOC_W-1:0] o_loc
);
    logic [3*LOC_W-1:0] r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld;
    t_state r_state, n_state;
    t_job r_job;
    logic [CNT_W-1:0] r_i;
    logic [IDX_W-1:0] idx;
    logic [3*LOC_W-1:0] r_rd;
    logic r_rd_v;
    logic [SQ_W-1:0] r_sq [3];
    logic [DIST_W-1:0] r_dist, r_best_d;
    logic [IDX_W-1:0] r_best, r_free;
    logic r_has_best, r_has_free, r_dup;
    t_status r_status;
    logic [3*LOC_W-1:0] r_out;
    logic [IDX_W-1:0] r_cur;
    logic signed [DIFF_W-1:0] diff [3];
    logic [DIFF_W-1:0] mag [3];

    assign idx = r_i[IDX_W-1:0];
    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_status = r_status;
    assign o_loc    = r_out;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            diff[a] = {{2{r_rd[a*LOC_W+LOC_W-1]}}, r_rd[a*LOC_W +: LOC_W], 8'd0}
                    - {{2{r_job.refp[a*REF_W+REF_W-1]}}, r_job.refp[a*REF_W +: REF_W]};
            mag[a] = diff[a][DIFF_W-1] ? DIFF_W'(-diff[a]) : diff[a];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_job_valid) n_state = S_SCAN;
            S_SCAN:   n_state = (r_job.cmd == CMD_TAKE) ? S_MUL : S_CMP;
            S_MUL:    n_state = S_SUM;
            S_SUM:    n_state = S_CMP;
            S_CMP:    n_state = (r_i == CNT_W'(TABLE_ENTRIES) || r_dup) ? S_FINISH : S_SCAN;
            S_FINISH: n_state = S_OUT;
            S_OUT:    if (i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FINISH) begin
                if (r_job.cmd == CMD_TAKE) begin
                    if (r_has_best) r_vld[r_best] <= 1'b0;
                end else if (!r_dup && r_has_free) begin
                    r_vld[r_free] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && r_job.cmd == CMD_INSERT && !r_dup && r_has_free)
            r_mem[r_free] <= r_job.loc;
        if (r_state == S_SCAN) begin
            r_rd   <= r_mem[idx];
            r_rd_v <= r_vld[idx];
            r_cur  <= idx;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_job_valid) begin
                r_job      <= i_job;
                r_i        <= '0;
                r_has_best <= 1'b0;
                r_has_free <= 1'b0;
                r_dup      <= 1'b0;
                r_best     <= '0;
                r_free     <= '0;
                r_best_d   <= '0;
            end
            S_SCAN: r_i <= r_i + 1'b1;
            S_MUL: for (int a = 0; a < 3; a++) r_sq[a] <= SQ_W'(mag[a]) * SQ_W'(mag[a]);
            S_SUM: r_dist <= DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]) + DIST_W'(r_sq[2]);
            S_CMP: begin
                if (r_job.cmd == CMD_TAKE) begin
                    if (r_rd_v && (!r_has_best || r_dist < r_best_d)) begin
                        r_has_best <= 1'b1;
                        r_best     <= r_cur;
                        r_best_d   <= r_dist;
                        r_out      <= r_rd;
                    end
                end else if (r_rd_v) begin
                    if (r_rd == r_job.loc) r_dup <= 1'b1;
                end else if (!r_has_free) begin
                    r_has_free <= 1'b1;
                    r_free     <= r_cur;
                end
            end
            S_FINISH: begin
                if (r_job.cmd == CMD_TAKE) begin
                    r_status <= r_has_best ? ST_TAKEN : ST_EMPTY;
                    if (!r_has_best) r_out <= '0;
                end else begin
                    r_out    <= '0;
                    r_status <= r_dup ? ST_PRESENT : (r_has_free ? ST_INSERTED : ST_FULL);
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
